/* design/kce_pkg.sv */
// Shared types, constants and command codes for the keyframe curve evaluator.
package kce_pkg;

  localparam int unsigned MaxKeysDefault = 256;
  localparam logic [31:0] DegToRadQ32 = 32'd74961321;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_EVAL   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_INTERP  = 2'd0,
    ST_SINGLE  = 2'd1,
    ST_CLAMPED = 2'd2,
    ST_NOKEYS  = 2'd3
  } status_t;

  // One evaluate job handed from the front to the back.
  typedef struct packed {
    logic [31:0] query_time;
    logic [9:0]  model;
    logic [3:0]  channel;
  } job_t;

  function automatic logic is_rot(input logic [3:0] ch);
    is_rot = (ch == 4'd3) || (ch == 4'd4) || (ch == 4'd5);
  endfunction

endpackage

/* design/keyframe_curve_evaluator.sv */
// Top level of the keyframe curve evaluator.
//  channel | handshake         | payload
//  in_     | in_valid/in_stall | command, key_time, key_value, query_time, model, channel
//  out_    | out_valid/out_stall | curve_value, model_out, channel_out, status
// Append, clear: taken once no evaluate is queued or running.
// Evaluate: a popped job passes through key read, first key, key scan, multiply and
// restoring divide and scaling to the result beat; rotation channels add a rounding step.
// Empty, single-key and clamped curves skip the divide; a clamp scans every key.
// The key scan reads one key per cycle from the single-port key RAMs.
// Reset is synchronous; the key store needs no clearing pass.
module keyframe_curve_evaluator #(
  parameter int unsigned MaxKeys = kce_pkg::MaxKeysDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_key_time,
  input  logic [31:0] in_key_value,
  input  logic [31:0] in_query_time,
  input  logic [9:0]  in_model_number,
  input  logic [3:0]  in_channel_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_curve_value,
  output logic [9:0]  out_model_out,
  output logic [3:0]  out_channel_out,
  output logic [1:0]  out_status
);
  import kce_pkg::*;
  localparam int unsigned AW = $clog2(MaxKeys);

  logic busy, q_pop, q_valid, wr_en;
  job_t q_job;
  logic [AW-1:0] wr_addr, rd_addr, addr;
  logic [31:0] wr_time, wr_value, rd_time, rd_value;
  logic [AW:0] key_count;

  kce_front #(.MaxKeys(MaxKeys)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_command, .in_key_time, .in_key_value,
    .in_query_time, .in_model_number, .in_channel_number, .back_busy(busy),
    .q_pop, .q_valid, .q_job, .wr_en, .wr_addr, .wr_time, .wr_value, .key_count
  );

  assign addr = wr_en ? wr_addr : rd_addr;

  kce_ram #(.Width(32), .Depth(MaxKeys)) u_times (
    .clk, .we(wr_en), .addr, .wdata(wr_time), .rdata(rd_time));
  kce_ram #(.Width(32), .Depth(MaxKeys)) u_values (
    .clk, .we(wr_en), .addr, .wdata(wr_value), .rdata(rd_value));

  kce_back #(.MaxKeys(MaxKeys)) u_back (
    .clk, .rst_n, .q_valid, .q_job, .q_pop, .busy, .key_count, .rd_addr,
    .rd_time, .rd_value, .out_valid, .out_stall, .out_curve_value,
    .out_model_out, .out_channel_out, .out_status
  );
endmodule

/* design/kce_ram.sv */
// Generic single-port RAM with registered read.
module kce_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

/* design/kce_front.sv */
// Front: accepts beats, tracks key count, posts evaluate jobs to a queue.
module kce_front #(
  parameter int unsigned MaxKeys = kce_pkg::MaxKeysDefault
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_command,
  input  logic [31:0]                in_key_time,
  input  logic [31:0]                in_key_value,
  input  logic [31:0]                in_query_time,
  input  logic [9:0]                 in_model_number,
  input  logic [3:0]                 in_channel_number,
  input  logic                       back_busy,
  input  logic                       q_pop,
  output logic                       q_valid,
  output kce_pkg::job_t              q_job,
  output logic                       wr_en,
  output logic [$clog2(MaxKeys)-1:0] wr_addr,
  output logic [31:0]                wr_time,
  output logic [31:0]                wr_value,
  output logic [$clog2(MaxKeys):0]   key_count
);
  import kce_pkg::*;
  localparam int unsigned CW = $clog2(MaxKeys) + 1;

  job_t             q_r [2];
  logic [1:0]       q_cnt_r, q_cnt_nxt;
  logic             q_rd_r, q_wr_r;
  logic [CW-1:0]    cnt_r;
  logic             acc, push, mod_keys;
  cmd_t             cmd;

  assign cmd = cmd_t'(in_command);
  // Key store edits wait until the back is idle and no job is queued.
  assign mod_keys = (cmd == CMD_APPEND) || (cmd == CMD_CLEAR);
  assign in_stall = mod_keys ? (back_busy || q_cnt_r != 2'd0) : (q_cnt_r == 2'd2);
  assign acc  = in_valid && !in_stall;
  assign push = acc && cmd == CMD_EVAL;

  assign wr_en    = acc && cmd == CMD_APPEND && cnt_r < CW'(MaxKeys);
  assign wr_addr  = cnt_r[CW-2:0];
  assign wr_time  = in_key_time;
  assign wr_value = in_key_value;
  assign key_count = cnt_r;

  assign q_valid = q_cnt_r != 2'd0;
  assign q_job   = q_r[q_rd_r];

  always_comb begin
    q_cnt_nxt = q_cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      q_cnt_r <= '0;
      q_rd_r <= 1'b0;
      q_wr_r <= 1'b0;
    end else begin
      if (wr_en) cnt_r <= cnt_r + CW'(1);
      else if (acc && cmd == CMD_CLEAR) cnt_r <= '0;
      q_cnt_r <= q_cnt_nxt;
      if (push) q_wr_r <= ~q_wr_r;
      if (q_pop) q_rd_r <= ~q_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[q_wr_r] <= '{query_time: in_query_time, model: in_model_number,
                              channel: in_channel_number};
  end
endmodule

/* design/kce_back.sv */
// Back: scans keys, divides for the segment fraction, scales rotation, drives results.
module kce_back #(
  parameter int unsigned MaxKeys = kce_pkg::MaxKeysDefault
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  kce_pkg::job_t              q_job,
  output logic                       q_pop,
  output logic                       busy,
  input  logic [$clog2(MaxKeys):0]   key_count,
  output logic [$clog2(MaxKeys)-1:0] rd_addr,
  input  logic [31:0]                rd_time,
  input  logic [31:0]                rd_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [31:0]                out_curve_value,
  output logic [9:0]                 out_model_out,
  output logic [3:0]                 out_channel_out,
  output logic [1:0]                 out_status
);
  import kce_pkg::*;
  localparam int unsigned AW = $clog2(MaxKeys);
  localparam int unsigned CW = AW + 1;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RD0   = 10'b0000000010,
    S_FIRST = 10'b0000000100,
    S_SCAN  = 10'b0000001000,
    S_MUL   = 10'b0000010000,
    S_DIV   = 10'b0000100000,
    S_SC1   = 10'b0001000000,
    S_SC2   = 10'b0010000000,
    S_RND   = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t        st_r;
  job_t          job_r;
  logic [CW-1:0] idx_r;       // index of key now on read data
  logic [31:0]   t0_r, v0_r, first_t_r;
  logic [31:0]   v_r;
  logic [1:0]    stat_r;
  logic [63:0]   rem_r;
  logic [63:0]   quo_r;
  logic [32:0]   span_r;
  logic [31:0]   mag_r, off_r;
  logic          neg_r;
  logic [6:0]    bit_r;
  logic [63:0]   sc_r;
  logic [63:0]   sc_rnd;
  logic [31:0]   res_r;

  logic signed [31:0] tq, tk, tp;
  logic [64:0]   trial;
  assign tq = signed'(job_r.query_time);
  assign tk = signed'(rd_time);
  assign tp = signed'(t0_r);

  always_comb begin
    rd_addr = idx_r[AW-1:0];
    if (st_r == S_IDLE) rd_addr = '0;
    else if ((st_r == S_FIRST || st_r == S_SCAN) && idx_r + CW'(1) < CW'(MaxKeys))
      rd_addr = AW'(idx_r + CW'(1));
  end

  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign busy  = (st_r != S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_curve_value = res_r;
  assign out_model_out   = job_r.model;
  assign out_channel_out = job_r.channel;
  assign out_status      = stat_r;
  assign trial = {rem_r, quo_r[63]} - {32'd0, span_r};
  assign sc_rnd = sc_r + 64'h8000_0000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          job_r <= q_job;
          idx_r <= '0;
          st_r <= S_RD0;
        end
        S_RD0: begin
          if (key_count == '0) begin
            v_r <= '0; stat_r <= ST_NOKEYS; res_r <= '0; st_r <= S_OUT;
          end else st_r <= S_FIRST;
        end
        S_FIRST: begin
          t0_r <= rd_time; v0_r <= rd_value; first_t_r <= rd_time; v_r <= rd_value;
          idx_r <= idx_r + CW'(1);
          if (key_count == CW'(1)) begin
            stat_r <= ST_SINGLE; st_r <= S_SC1;
          end else st_r <= S_SCAN;
        end
        S_SCAN: begin
          if (tp <= tq && tq <= tk) begin
            span_r <= 33'($signed(tk) - $signed(tp));
            off_r  <= 32'($signed(tq) - $signed(tp));
            neg_r  <= $signed(rd_value) < $signed(v0_r);
            mag_r  <= ($signed(rd_value) < $signed(v0_r))
                      ? 32'($signed(v0_r) - $signed(rd_value))
                      : 32'($signed(rd_value) - $signed(v0_r));
            stat_r <= ST_INTERP;
            st_r <= S_MUL;
          end else if (idx_r + CW'(1) >= key_count) begin
            v_r <= ($signed(tq) < $signed(first_t_r)) ? v_r : rd_value;
            stat_r <= ST_CLAMPED;
            st_r <= S_SC1;
          end else begin
            t0_r <= rd_time; v0_r <= rd_value; idx_r <= idx_r + CW'(1);
          end
          // v_r keeps the first value for the low clamp
        end
        S_MUL: begin
          if (span_r == '0) begin
            v_r <= v0_r; st_r <= S_SC1;
          end else begin
            quo_r <= 64'(off_r) * 64'(mag_r);
            rem_r <= '0; bit_r <= '0; st_r <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (!trial[64]) begin
            rem_r <= trial[63:0]; quo_r <= {quo_r[62:0], 1'b1};
          end else begin
            rem_r <= {rem_r[62:0], quo_r[63]}; quo_r <= {quo_r[62:0], 1'b0};
          end
          bit_r <= bit_r + 7'd1;
          if (bit_r == 7'd63) st_r <= S_SC1;
        end
        S_SC1: begin
          if (stat_r == ST_INTERP && span_r != '0)
            v_r <= neg_r ? v0_r - quo_r[31:0] : v0_r + quo_r[31:0];
          st_r <= S_SC2;
        end
        S_SC2: begin
          if (is_rot(job_r.channel)) begin
            sc_r <= 64'($signed(v_r) < 0 ? 32'(-v_r) : v_r) * 64'(DegToRadQ32);
          end
          res_r <= v_r;
          st_r <= is_rot(job_r.channel) ? S_RND : S_OUT;
          idx_r <= {CW{1'b0}};
        end
        // round the degree product to nearest, halves away from zero
        S_RND: begin
          res_r <= $signed(v_r) < 0 ? 32'(-sc_rnd[63:32]) : sc_rnd[63:32];
          st_r <= S_OUT;
        end
        S_OUT: if (!out_stall) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

/* design/kce_checker.sv */
// Port-level assertions for the keyframe curve evaluator, bound to the top.
module kce_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_curve_value,
  input logic [3:0]  out_channel_out,
  input logic [1:0]  out_status
);
  import kce_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_curve_value))
    else $error("result dropped under stall");

  a_nokeys: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NOKEYS |-> out_curve_value == '0)
    else $error("no-key result not zero");

  a_ch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_channel_out) && $stable(out_status))
    else $error("result tags moved under stall");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid out of reset");
endmodule

bind keyframe_curve_evaluator kce_checker u_kce_checker (.*);
